@@ design/xcfp_pkg.sv @@
// Shared types, phase codes, result kinds and register indexes for the frame parser.
package xcfp_pkg;

	localparam int LENGTH_BITS_DEFAULT = 16;
	localparam int LEN_W               = 16;
	localparam int BYTE_W              = 8;

	localparam logic [BYTE_W-1:0] START_BYTE_RESET  = 8'h00;
	localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 16'd256;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_SEQ    = 3'd3,
		PH_CMD    = 3'd4,
		PH_STATUS = 3'd5,
		PH_DATA   = 3'd6,
		PH_CHECK  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_LONG = 2'd3
	} kind_t;

	typedef enum logic {
		REG_START_BYTE  = 1'b0,
		REG_MAX_PAYLOAD = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [LEN_W-1:0]  max_payload;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] seq_num;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] status_code;
		logic [LEN_W-1:0]  payload_length;
		logic              last;
	} result_t;

endpackage

@@ design/xcfp_cfg.sv @@
// Configuration register file holding the start byte and the payload length limit.
module xcfp_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output xcfp_pkg::cfg_t    cfg
);

	logic [xcfp_pkg::BYTE_W-1:0] start_byte_q;
	logic [xcfp_pkg::LEN_W-1:0]  max_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= xcfp_pkg::START_BYTE_RESET;
			max_payload_q <= xcfp_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_valid) begin
			unique case (xcfp_pkg::reg_index_t'(cfg_index))
				xcfp_pkg::REG_START_BYTE: begin
					start_byte_q <= cfg_data[xcfp_pkg::BYTE_W-1:0];
				end
				xcfp_pkg::REG_MAX_PAYLOAD: begin
					max_payload_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.start_byte  = start_byte_q;
	assign cfg.max_payload = max_payload_q;

endmodule

@@ design/xcfp_core.sv @@
// Frame phase sequencer, held header fields, checksum and result decode.
module xcfp_core #(
	parameter int LENGTH_BITS = xcfp_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [xcfp_pkg::BYTE_W-1:0] rx_byte,
	input  xcfp_pkg::cfg_t              cfg,
	output logic                        res_valid,
	output xcfp_pkg::result_t           res
);

	xcfp_pkg::phase_t            phase_q, phase_d;
	logic [xcfp_pkg::LEN_W-1:0]  length_q, length_d;
	logic [LENGTH_BITS-1:0]      left_q, left_d;
	logic [xcfp_pkg::BYTE_W-1:0] xor_q, xor_d;
	logic [xcfp_pkg::BYTE_W-1:0] seq_q, seq_d;
	logic [xcfp_pkg::BYTE_W-1:0] cmd_q, cmd_d;
	logic [xcfp_pkg::BYTE_W-1:0] stat_q, stat_d;
	logic [xcfp_pkg::LEN_W-1:0]  len_full;
	logic                        too_long;
	logic [LENGTH_BITS-1:0]      left_dec;

	assign len_full = {rx_byte, length_q[xcfp_pkg::BYTE_W-1:0]};
	// A length that overflows the counter is rejected like one above the limit.
	assign too_long = (len_full > cfg.max_payload) ||
	                  ((len_full >> LENGTH_BITS) != {xcfp_pkg::LEN_W{1'b0}});
	assign left_dec = left_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d   = phase_q;
		length_d  = length_q;
		left_d    = left_q;
		xor_d     = xor_q ^ rx_byte;
		seq_d     = seq_q;
		cmd_d     = cmd_q;
		stat_d    = stat_q;
		res_valid = 1'b0;
		res.kind           = xcfp_pkg::KIND_DATA;
		res.data           = '0;
		res.last           = 1'b0;
		unique case (phase_q)
			xcfp_pkg::PH_HUNT: begin
				xor_d = xor_q;
				if (rx_byte == cfg.start_byte) begin
					length_d = '0;
					left_d   = '0;
					xor_d    = '0;
					seq_d    = '0;
					cmd_d    = '0;
					stat_d   = '0;
					phase_d  = xcfp_pkg::PH_LEN_LO;
				end
			end
			xcfp_pkg::PH_LEN_LO: begin
				length_d = {{(xcfp_pkg::LEN_W-xcfp_pkg::BYTE_W){1'b0}}, rx_byte};
				phase_d  = xcfp_pkg::PH_LEN_HI;
			end
			xcfp_pkg::PH_LEN_HI: begin
				length_d = len_full;
				if (too_long) begin
					res_valid = 1'b1;
					res.kind  = xcfp_pkg::KIND_LONG;
					res.last  = 1'b1;
					phase_d   = xcfp_pkg::PH_HUNT;
				end else begin
					left_d  = len_full[LENGTH_BITS-1:0];
					phase_d = xcfp_pkg::PH_SEQ;
				end
			end
			xcfp_pkg::PH_SEQ: begin
				seq_d   = rx_byte;
				phase_d = xcfp_pkg::PH_CMD;
			end
			xcfp_pkg::PH_CMD: begin
				cmd_d   = rx_byte;
				phase_d = xcfp_pkg::PH_STATUS;
			end
			xcfp_pkg::PH_STATUS: begin
				stat_d  = rx_byte;
				phase_d = (left_q == '0) ? xcfp_pkg::PH_CHECK : xcfp_pkg::PH_DATA;
			end
			xcfp_pkg::PH_DATA: begin
				res_valid = 1'b1;
				res.data  = rx_byte;
				left_d    = left_dec;
				if (left_dec == '0) begin
					phase_d = xcfp_pkg::PH_CHECK;
				end
			end
			xcfp_pkg::PH_CHECK: begin
				res_valid = 1'b1;
				res.kind  = (rx_byte == xor_q) ? xcfp_pkg::KIND_GOOD : xcfp_pkg::KIND_BAD;
				res.last  = 1'b1;
				phase_d   = xcfp_pkg::PH_HUNT;
			end
			default: begin
				phase_d = xcfp_pkg::PH_HUNT;
			end
		endcase
		// The payload length reflects the state after this byte, as the length
		// byte itself is reported on a length error; other fields are held values.
		res.seq_num        = seq_q;
		res.command        = cmd_q;
		res.status_code    = stat_q;
		res.payload_length = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= xcfp_pkg::PH_HUNT;
			length_q <= '0;
			left_q   <= '0;
			xor_q    <= '0;
			seq_q    <= '0;
			cmd_q    <= '0;
			stat_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			left_q   <= left_d;
			xor_q    <= xor_d;
			seq_q    <= seq_d;
			cmd_q    <= cmd_d;
			stat_q   <= stat_d;
		end
	end

endmodule

@@ design/xor_checked_frame_parser.sv @@
// Top level of the XOR-checked, length-prefixed frame parser with its stream ports.
// A result beat is decoded from the byte held in the input stage and offered
// from the output register, which drives m_tvalid. Throughput: one input beat
// per cycle, whatever the phase of the frame, while the receiver takes results.
// Reset (arst_n low, asynchronous): both stages empty, parser hunting for the
// start byte, start_byte 0 and max_payload 256.
module xor_checked_frame_parser #(
	parameter int LENGTH_BITS = xcfp_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Received byte stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] data, [15:8] seq_num, [23:16] command,
	                               // [31:24] status_code, [47:32] payload_length
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,   // last
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	xcfp_pkg::cfg_t    cfg;
	xcfp_pkg::result_t res;
	xcfp_pkg::result_t out_q;
	logic              res_valid;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	logic              out_free;
	logic              advance;

	// Registers stay writable; the user writes the block only while idle, unenforced.
	assign cfg_ready = 1'b1;

	xcfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The byte in the input stage is consumed when it yields no result, or when
	// the output register is empty or being drained in this same cycle. The
	// parser state moves on only then, so a stalled beat is decoded again
	// unchanged in the next cycle.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	xcfp_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: loaded with a fresh result, or emptied once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.payload_length, out_q.status_code, out_q.command,
	                   out_q.seq_num, out_q.data};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the XOR-checked, length-prefixed frame parser.
`timescale 1ns / 1ps

module tb;
	import xcfp_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;

	typedef logic [7:0] byte_q_t[$];

	// Scoreboard: a cycle-free model of the parser, fed with every accepted input beat,
	// and the queue of result beats that the model says must come out, oldest first.
	class frame_scoreboard;
		logic [7:0]  start_byte;
		logic [15:0] max_payload;
		phase_t      phase;
		logic [15:0] length_held;
		logic [15:0] bytes_left;
		logic [7:0]  running_xor;
		logic [7:0]  seq_held;
		logic [7:0]  command_held;
		logic [7:0]  status_held;
		result_t     due_results[$];
		int          mismatches;

		function new();
			start_byte   = START_BYTE_RESET;
			max_payload  = MAX_PAYLOAD_RESET;
			phase        = PH_HUNT;
			length_held  = '0;
			bytes_left   = '0;
			running_xor  = '0;
			seq_held     = '0;
			command_held = '0;
			status_held  = '0;
			mismatches   = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [15:0] value);
			if (idx == REG_START_BYTE)
				start_byte = value[7:0];
			else
				max_payload = value;
		endfunction

		// Every result carries the header of the frame as it stands at that moment.
		function result_t frame_result(kind_t kind, logic [7:0] data, logic last);
			result_t r;
			r.kind           = kind;
			r.data           = data;
			r.seq_num        = seq_held;
			r.command        = command_held;
			r.status_code    = status_held;
			r.payload_length = length_held;
			r.last           = last;
			return r;
		endfunction

		// Advances the model by one received byte and queues the result it causes.
		// At the default counter width no 16-bit length can overflow the counter, so
		// the only rejection is a length above max_payload.
		function void note_rx_byte(logic [7:0] b);
			case (phase)
				PH_HUNT: begin
					if (b == start_byte) begin
						length_held  = '0;
						bytes_left   = '0;
						running_xor  = '0;
						seq_held     = '0;
						command_held = '0;
						status_held  = '0;
						phase        = PH_LEN_LO;
					end
				end
				PH_LEN_LO: begin
					running_xor ^= b;
					length_held = {8'h00, b};
					phase       = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					running_xor ^= b;
					length_held[15:8] = b;
					if (length_held > max_payload) begin
						due_results.push_back(frame_result(KIND_LONG, 8'h00, 1'b1));
						phase = PH_HUNT;
					end else begin
						bytes_left = length_held;
						phase      = PH_SEQ;
					end
				end
				PH_SEQ: begin
					running_xor ^= b;
					seq_held = b;
					phase    = PH_CMD;
				end
				PH_CMD: begin
					running_xor ^= b;
					command_held = b;
					phase        = PH_STATUS;
				end
				PH_STATUS: begin
					running_xor ^= b;
					status_held = b;
					if (bytes_left == 16'd0)
						phase = PH_CHECK;
					else
						phase = PH_DATA;
				end
				PH_DATA: begin
					running_xor ^= b;
					due_results.push_back(frame_result(KIND_DATA, b, 1'b0));
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 16'd0)
						phase = PH_CHECK;
				end
				default: begin
					if (b == running_xor)
						due_results.push_back(frame_result(KIND_GOOD, 8'h00, 1'b1));
					else
						due_results.push_back(frame_result(KIND_BAD, 8'h00, 1'b1));
					phase = PH_HUNT;
				end
			endcase
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result beat, expected none, got kind %0d data 0x%0h",
					$time, got.kind, got.data);
				return;
			end
			want = due_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("data", want.data, got.data);
			compare_field("seq_num", want.seq_num, got.seq_num);
			compare_field("command", want.command, got.command);
			compare_field("status_code", want.status_code, got.status_code);
			compare_field("payload_length", want.payload_length, got.payload_length);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	frame_scoreboard board;
	int          items_sent;   // beats that the parser acts upon; ignored hunt bytes are left out
	int          beats_sent;
	logic        src_quiet;    // when set, the sender runs back to back
	logic        sink_quiet;   // when set, the receiver never stalls
	int          cycle_count;

	xor_checked_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A byte that the parser drops while hunting, since it differs from the start byte.
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == board.start_byte)
			b ^= 8'h01;
		return b;
	endfunction

	// Drives one byte and returns at the edge where it is accepted. The valid is only
	// lowered when a gap follows, so that a back-to-back beat sees a single assignment.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		beats_sent++;
		if (beats_sent % 48 == 0)
			src_quiet = ($urandom_range(0, 3) == 0);
		gap = src_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (board.phase != PH_HUNT || b == board.start_byte)
			items_sent++;
		board.note_rx_byte(b);
	endtask

	// Sends a whole frame from the start byte on. When the length is rejected the parser
	// hunts again straight away, so the rest of the frame is not sent.
	task automatic send_frame(input logic [15:0] len, input logic [7:0] seq,
	                          input logic [7:0] cmd, input logic [7:0] st,
	                          input byte_q_t payload, input logic corrupt);
		logic [7:0] sum;
		sum = len[7:0] ^ len[15:8] ^ seq ^ cmd ^ st;
		send_byte(board.start_byte);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		if (board.phase == PH_HUNT)
			return;
		send_byte(seq);
		send_byte(cmd);
		send_byte(st);
		foreach (payload[i]) begin
			send_byte(payload[i]);
			sum ^= payload[i];
		end
		send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
	endtask

	// Completes a frame that an earlier phase left open, keeping the length small so that
	// a wide max_payload cannot turn it into a very long frame.
	task automatic finish_open_frame();
		logic [7:0] b;
		while (board.phase != PH_HUNT) begin
			case (board.phase)
				PH_LEN_LO: b = 8'($urandom_range(0, 15));
				PH_LEN_HI: b = (board.max_payload > 16'd4000) ? 8'h00 : 8'($urandom);
				PH_CHECK:  b = ($urandom_range(0, 9) < 7) ? board.running_xor : 8'($urandom);
				default:   b = 8'($urandom);
			endcase
			send_byte(b);
		end
	endtask

	// Leaves a frame open at the end of a phase, so that the next register writes land
	// in the middle of it; stopping after the low length byte lets the new max_payload
	// decide the length check.
	task automatic leave_frame_open();
		int n;
		send_byte(board.start_byte);
		send_byte(8'($urandom_range(0, 15)));
		n = $urandom_range(0, 3);
		if (n > 0)
			send_byte(8'h00);
		for (int k = 1; k < n; k++)
			send_byte(8'($urandom));
	endtask

	// Waits until every expected result beat has come out, then lets the pipeline settle,
	// since a byte that causes no result may still be on its way through.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Writes both registers once the input is stopped and every due result is out. The
	// upper byte of the start_byte word is junk that the block must ignore.
	task automatic set_registers(input logic [7:0] sb, input logic [15:0] mx);
		logic [15:0] word;
		wait_drained();
		word = {8'($urandom), sb};
		cfg_valid <= 1'b1;
		cfg_index <= REG_START_BYTE;
		cfg_data  <= word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(REG_START_BYTE, word);
		cfg_index <= REG_MAX_PAYLOAD;
		cfg_data  <= mx;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(REG_MAX_PAYLOAD, mx);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic: mostly well-formed frames with random content and a share of bad
	// checksums, mixed with oversized lengths followed by leftover bytes and line noise.
	task automatic run_random(input int target);
		int          first;
		int          r;
		int          n;
		logic [15:0] len;
		logic [15:0] cap;
		byte_q_t     body;
		first = items_sent;
		while (items_sent - first < target) begin
			finish_open_frame();
			r   = $urandom_range(0, 99);
			cap = board.max_payload;
			body.delete();
			if (r < 72) begin
				if (cap <= 16'd64 && $urandom_range(0, 5) == 0)
					len = cap;
				else if ($urandom_range(0, 9) == 0)
					len = 16'($urandom_range(0, (cap < 16'd40) ? cap : 40));
				else
					len = 16'($urandom_range(0, (cap < 16'd8) ? cap : 8));
				repeat (len) body.push_back(8'($urandom));
				send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), body,
					$urandom_range(0, 4) == 0);
			end else if (r < 86 && cap != 16'hFFFF) begin
				case ($urandom_range(0, 2))
					0:       len = cap + 16'd1;
					1:       len = 16'hFFFF;
					default: len = 16'($urandom_range(cap + 1, 16'hFFFF));
				endcase
				send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), body, 1'b0);
				n = $urandom_range(0, 3);
				repeat (n) send_byte(noise_byte());
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(noise_byte());
			end
		end
	endtask

	// Receiver: checks every accepted result beat against the scoreboard and stalls at
	// random, with stretches where it never stalls.
	initial begin
		result_t seen;
		int      stall_left;
		int      span;
		m_tready   <= 1'b0;
		stall_left = 0;
		span       = 0;
		sink_quiet = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				seen.kind           = kind_t'(m_tuser);
				seen.data           = m_tdata[7:0];
				seen.seq_num        = m_tdata[15:8];
				seen.command        = m_tdata[23:16];
				seen.status_code    = m_tdata[31:24];
				seen.payload_length = m_tdata[47:32];
				seen.last           = m_tlast;
				board.check_result(seen);
			end
			if (span == 0) begin
				span       = $urandom_range(50, 300);
				sink_quiet = ($urandom_range(0, 3) == 0);
			end
			span--;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = sink_quiet ? 0 : pick_gap();
				m_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		byte_q_t body;
		board      = new();
		items_sent = 0;
		beats_sent = 0;
		src_quiet  = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= REG_START_BYTE;
		cfg_data  <= 16'h0000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset settings (start byte zero, max_payload 256).
		// A stray byte while hunting is dropped.
		send_byte(8'h5A);
		// Good frame with extreme header bytes; its payload carries the start byte,
		// which must pass as plain data.
		body = '{8'hFF, 8'h00};
		send_frame(16'd2, 8'hFF, 8'h80, 8'h01, body, 1'b0);
		// Length one above the maximum: rejected at once, and the header of the frame
		// before must not leak into the verdict, as the held bytes are cleared.
		body.delete();
		send_frame(16'd257, 8'h00, 8'h00, 8'h00, body, 1'b0);
		send_byte(8'h33);
		// Empty payload, so the byte after the status byte is the checksum; here wrong.
		send_frame(16'd0, 8'h12, 8'h34, 8'h56, body, 1'b1);
		// Register write in the middle of a frame: the new max_payload governs the
		// length check that is still to come, so a length of 16 is refused.
		send_byte(board.start_byte);
		send_byte(8'h10);
		set_registers(8'h00, 16'd15);
		send_byte(8'h00);

		// Random phases over a range of settings, the extremes among them.
		set_registers(8'h00, 16'd256);
		run_random(110);
		leave_frame_open();
		set_registers(8'hFF, 16'd0);
		run_random(90);
		set_registers(8'h7E, 16'hFFFF);
		run_random(110);
		set_registers(8'h80, 16'hFFFE);
		run_random(90);
		leave_frame_open();
		set_registers(8'hA5, 16'd1);
		run_random(90);
		leave_frame_open();
		repeat (3) begin
			set_registers(8'($urandom), 16'($urandom_range(0, 300)));
			run_random(90);
			if ($urandom_range(0, 1) == 0)
				leave_frame_open();
		end

		wait_drained();
		if (board.mismatches == 0 && board.due_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
